[rtl/core/fbpm_pkg.sv]
// ----------------------------------------------------------------------------
// fbpm_pkg
// Shared types and codes for the frame buffer pool manager: field widths,
// command and status codes, free FIFO request bundle and filled list entry.
// ----------------------------------------------------------------------------
package fbpm_pkg;

    localparam int ID_W       = 4;
    localparam int FRAME_W    = 32;
    localparam int HANDLE_W   = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 5;
    localparam int CFG_W      = 5;
    localparam int RESET_BUFS = 16;

    typedef logic [ID_W-1:0]     t_id;
    typedef logic [FRAME_W-1:0]  t_frame;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [TOTAL_W-1:0]  t_total;

    localparam t_op OP_ACQUIRE = 3'd0;
    localparam t_op OP_COMMIT  = 3'd1;
    localparam t_op OP_GET     = 3'd2;
    localparam t_op OP_RELEASE = 3'd3;
    localparam t_op OP_RESET   = 3'd4;
    localparam t_op OP_REPEAT  = 3'd5;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NONE      = 2'd1;
    localparam t_status ST_MISMATCH  = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic init;
        logic pop;
        logic push;
    } t_free_req;

    typedef struct packed {
        t_id     id;
        t_frame  frame;
        t_handle handle;
    } t_entry;

endpackage

[rtl/core/frame_buffer_pool_manager.sv]
// ----------------------------------------------------------------------------
// frame_buffer_pool_manager
// Frame buffer pool: free FIFO, ordered filled list with a delivery mark,
// and a command sequencer that walks the filled list memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears for one cycle with o_done, and the receiver cannot stall it. The
// filled list has one read port, so list walks go one entry per cycle.
// Release searches the handed-out entries for the handle and, on a match,
// shifts the later entries down; repeat check searches the whole filled list,
// and reset waiting returns the ids past the delivery mark to the free FIFO.
// After reset and after every buffer_count write the free FIFO is refilled in
// a sweep over its whole memory, with busy held high. A buffer_count write is
// taken only while idle with start low.
module frame_buffer_pool_manager #(
    parameter int POOL_SIZE = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  fbpm_pkg::t_op            i_op,
    input  fbpm_pkg::t_id            i_buffer_id,
    input  fbpm_pkg::t_frame         i_frame_no,
    input  fbpm_pkg::t_handle        i_handle,
    output logic                     o_done,
    output fbpm_pkg::t_status        o_status,
    output fbpm_pkg::t_id            o_out_buffer_id,
    output fbpm_pkg::t_frame         o_out_frame_no,
    output fbpm_pkg::t_handle        o_out_handle,
    output logic                     o_repeat_found,
    output fbpm_pkg::t_total         o_filled_total,
    output fbpm_pkg::t_total         o_handed_out_total,
    output fbpm_pkg::t_total         o_free_total,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [fbpm_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(POOL_SIZE);
    localparam int CW = $clog2(POOL_SIZE + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(POOL_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WAIT,
        S_SEARCH,
        S_SHIFT,
        S_DRAIN
    } t_state;

    t_state            r_state, n_state;
    fbpm_pkg::t_op     r_op, n_op;
    fbpm_pkg::t_id     r_bid, n_bid;
    fbpm_pkg::t_frame  r_fidx, n_fidx;
    fbpm_pkg::t_handle r_hnd, n_hnd;
    logic [CW-1:0]     r_fcount, n_fcount;
    logic [CW-1:0]     r_mark, n_mark;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic              r_done, n_done;
    fbpm_pkg::t_status r_status, n_status;
    fbpm_pkg::t_id     r_oid, n_oid;
    fbpm_pkg::t_frame  r_ofi, n_ofi;
    fbpm_pkg::t_handle r_oh, n_oh;
    logic              r_rep, n_rep;

    fbpm_pkg::t_free_req w_free_req;
    fbpm_pkg::t_id       w_pop_id;
    logic [CW-1:0]       w_free_count;
    logic                w_free_busy;
    logic [CW-1:0]       w_cfg_count;

    logic                w_ram_we;
    logic [AW-1:0]       w_ram_waddr;
    fbpm_pkg::t_entry    w_ram_wdata;
    logic [AW-1:0]       w_ram_raddr;
    fbpm_pkg::t_entry    w_ram_rdata;

    logic                w_hit;
    logic [CW-1:0]       w_limit;
    logic [CW-1:0]       w_dst;
    logic                w_cfg_take;

    assign w_cfg_count = (int'(i_cfg_data) > POOL_SIZE) ? FULL_COUNT : CW'(i_cfg_data);
    assign w_hit       = (r_op == fbpm_pkg::OP_RELEASE) ? (w_ram_rdata.handle == r_hnd)
                                                        : (w_ram_rdata.frame == r_fidx);
    assign w_limit     = (r_op == fbpm_pkg::OP_RELEASE) ? r_mark : r_fcount;
    assign w_dst       = r_pidx - CW'(1);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign w_cfg_take  = i_cfg_valid && o_cfg_ready;
    assign busy        = (r_state != S_IDLE) || w_free_busy;

    fbpm_free_fifo #(
        .POOL_SIZE (POOL_SIZE)
    ) u_free_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (w_free_req),
        .i_init_count (w_cfg_count),
        .i_push_id    (w_ram_rdata.id),
        .o_pop_id     (w_pop_id),
        .o_count      (w_free_count),
        .o_busy       (w_free_busy)
    );

    fbpm_filled_ram #(
        .POOL_SIZE (POOL_SIZE)
    ) u_filled_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_bid    = r_bid;
        n_fidx   = r_fidx;
        n_hnd    = r_hnd;
        n_fcount = r_fcount;
        n_mark   = r_mark;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pend   = r_pend;
        n_done   = 1'b0;
        n_status = r_status;
        n_oid    = r_oid;
        n_ofi    = r_ofi;
        n_oh     = r_oh;
        n_rep    = r_rep;

        w_free_req  = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_fcount[AW-1:0];
        w_ram_wdata = '{id: r_bid, frame: r_fidx, handle: r_hnd};
        w_ram_raddr = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_cfg_take) begin
                    w_free_req.init = 1'b1;
                    n_fcount        = '0;
                    n_mark          = '0;
                end else if (start && !busy) begin
                    n_op    = i_op;
                    n_bid   = i_buffer_id;
                    n_fidx  = i_frame_no;
                    n_hnd   = i_handle;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status = fbpm_pkg::ST_OK;
                n_oid    = '0;
                n_ofi    = '0;
                n_oh     = '0;
                n_rep    = 1'b0;
                n_idx    = '0;
                n_pend   = 1'b0;
                case (r_op)
                    fbpm_pkg::OP_ACQUIRE: begin
                        if (w_free_count == '0) begin
                            n_status = fbpm_pkg::ST_NONE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            w_free_req.pop = 1'b1;
                            n_state        = S_WAIT;
                        end
                    end
                    fbpm_pkg::OP_COMMIT: begin
                        if (r_fcount == FULL_COUNT) begin
                            n_status = fbpm_pkg::ST_NONE;
                        end else begin
                            w_ram_we = 1'b1;
                            n_fcount = r_fcount + CW'(1);
                        end
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                    fbpm_pkg::OP_GET: begin
                        if (r_mark < r_fcount) begin
                            w_ram_raddr = r_mark[AW-1:0];
                            n_state     = S_WAIT;
                        end else begin
                            n_status = fbpm_pkg::ST_NONE;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    fbpm_pkg::OP_RELEASE: begin
                        n_status = fbpm_pkg::ST_NOT_FOUND;
                        n_state  = S_SEARCH;
                    end
                    fbpm_pkg::OP_RESET: begin
                        n_idx   = r_mark;
                        n_state = S_DRAIN;
                    end
                    fbpm_pkg::OP_REPEAT: begin
                        n_state = S_SEARCH;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WAIT: begin
                if (r_op == fbpm_pkg::OP_ACQUIRE) begin
                    n_oid = w_pop_id;
                end else begin
                    n_oid  = w_ram_rdata.id;
                    n_ofi  = w_ram_rdata.frame;
                    n_oh   = w_ram_rdata.handle;
                    n_mark = r_mark + CW'(1);
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (r_pend && w_hit) begin
                    if (r_op == fbpm_pkg::OP_RELEASE) begin
                        n_oid = w_ram_rdata.id;
                        if (w_ram_rdata.frame != r_fidx) begin
                            n_status = fbpm_pkg::ST_MISMATCH;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_status        = fbpm_pkg::ST_OK;
                            w_free_req.push = 1'b1;
                            n_mark          = r_mark - CW'(1);
                            n_idx           = r_pidx + CW'(1);
                            n_pend          = 1'b0;
                            n_state         = S_SHIFT;
                        end
                    end else begin
                        n_rep   = 1'b1;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_idx == w_limit) begin
                    n_pend  = 1'b0;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = w_dst[AW-1:0];
                    w_ram_wdata = w_ram_rdata;
                end
                if (r_idx < r_fcount) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_fcount = r_fcount - CW'(1);
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (r_pend) begin
                    w_free_req.push = 1'b1;
                end
                if (r_idx < r_fcount) begin
                    n_pend = 1'b1;
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_fcount = r_mark;
                        n_done   = 1'b1;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fcount <= '0;
            r_mark   <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fcount <= n_fcount;
            r_mark   <= n_mark;
            r_pend   <= n_pend;
            r_done   <= n_done;
            r_op     <= n_op;
            r_bid    <= n_bid;
            r_fidx   <= n_fidx;
            r_hnd    <= n_hnd;
            r_idx    <= n_idx;
            r_pidx   <= n_pidx;
            r_status <= n_status;
            r_oid    <= n_oid;
            r_ofi    <= n_ofi;
            r_oh     <= n_oh;
            r_rep    <= n_rep;
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_out_buffer_id    = r_oid;
    assign o_out_frame_no     = r_ofi;
    assign o_out_handle       = r_oh;
    assign o_repeat_found     = r_rep;
    assign o_filled_total     = fbpm_pkg::t_total'(r_fcount);
    assign o_handed_out_total = fbpm_pkg::t_total'(r_mark);
    assign o_free_total       = fbpm_pkg::t_total'(w_free_count);

endmodule

[rtl/core/fbpm_free_fifo.sv]
// ----------------------------------------------------------------------------
// fbpm_free_fifo
// Circular free buffer FIFO in a one-port-write, one-port-read memory with a
// registered read. Init sweeps the memory with ids in order.
// ----------------------------------------------------------------------------
module fbpm_free_fifo #(
    parameter int  POOL_SIZE = 16,
    localparam int AW        = $clog2(POOL_SIZE),
    localparam int AW1       = AW + 1,
    localparam int CW        = $clog2(POOL_SIZE + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbpm_pkg::t_free_req i_req,
    input  logic [CW-1:0]       i_init_count,
    input  fbpm_pkg::t_id       i_push_id,
    output fbpm_pkg::t_id       o_pop_id,
    output logic [CW-1:0]       o_count,
    output logic                o_busy
);

    localparam logic [CW-1:0]  RESET_COUNT = CW'((POOL_SIZE < fbpm_pkg::RESET_BUFS) ?
                                                 POOL_SIZE : fbpm_pkg::RESET_BUFS);
    localparam logic [CW-1:0]  FULL_COUNT  = CW'(POOL_SIZE);
    localparam logic [AW1-1:0] POOL_EXT    = AW1'(POOL_SIZE);
    localparam logic [AW-1:0]  LAST_ADDR   = AW'(POOL_SIZE - 1);

    fbpm_pkg::t_id  r_mem [POOL_SIZE];
    fbpm_pkg::t_id  r_pop_id;
    logic [AW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic           r_sweep;
    logic [AW-1:0]  r_sweep_addr;

    logic [AW1-1:0] w_tail_sum;
    logic [AW-1:0]  w_tail;
    logic [AW-1:0]  w_head_next;
    logic           w_push_ok;

    assign w_tail_sum  = {1'b0, r_head} + AW1'(r_count);
    assign w_tail      = (w_tail_sum >= POOL_EXT) ? AW'(w_tail_sum - POOL_EXT) : AW'(w_tail_sum);
    assign w_head_next = (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
    assign w_push_ok   = i_req.push && (r_count != FULL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_head       <= '0;
            r_count      <= RESET_COUNT;
        end else if (i_req.init) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
            r_head       <= '0;
            r_count      <= i_init_count;
        end else begin
            if (r_sweep) begin
                r_sweep_addr <= r_sweep_addr + AW'(1);
                if (r_sweep_addr == LAST_ADDR) begin
                    r_sweep <= 1'b0;
                end
            end
            if (i_req.pop) begin
                r_head  <= w_head_next;
                r_count <= r_count - CW'(1);
            end else if (w_push_ok) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep) begin
            r_mem[r_sweep_addr] <= fbpm_pkg::t_id'(r_sweep_addr);
        end else if (w_push_ok) begin
            r_mem[w_tail] <= i_push_id;
        end
        r_pop_id <= r_mem[r_head];
    end

    assign o_pop_id = r_pop_id;
    assign o_count  = r_count;
    assign o_busy   = r_sweep;

endmodule

[rtl/core/fbpm_filled_ram.sv]
// ----------------------------------------------------------------------------
// fbpm_filled_ram
// Filled list storage: id, frame index and handle per position, one write
// port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fbpm_filled_ram #(
    parameter int  POOL_SIZE = 16,
    localparam int AW        = $clog2(POOL_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  fbpm_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output fbpm_pkg::t_entry o_rdata
);

    fbpm_pkg::t_entry r_mem [POOL_SIZE];
    fbpm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/fbpm_checker.sv]
// ----------------------------------------------------------------------------
// fbpm_checker
// Port-level checks for the frame buffer pool manager, bound to the top level.
// ----------------------------------------------------------------------------
module fbpm_checker #(
    parameter int POOL_SIZE = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input fbpm_pkg::t_status o_status,
    input fbpm_pkg::t_id     o_out_buffer_id,
    input fbpm_pkg::t_frame  o_out_frame_no,
    input fbpm_pkg::t_handle o_out_handle,
    input logic              o_repeat_found,
    input fbpm_pkg::t_total  o_filled_total,
    input fbpm_pkg::t_total  o_handed_out_total
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_done)
        else $error("accepted request did not raise busy");

    a_mark_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (POOL_SIZE > 31) || (o_handed_out_total <= o_filled_total))
        else $error("handed-out count exceeds filled count");

    a_fail_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != fbpm_pkg::ST_OK) |->
            (o_out_frame_no == '0) && (o_out_handle == '0) && !o_repeat_found)
        else $error("failed request carries frame data");

    a_none_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == fbpm_pkg::ST_NONE) |-> (o_out_buffer_id == '0))
        else $error("empty result carries a buffer id");

endmodule

bind frame_buffer_pool_manager fbpm_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_fbpm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_done             (o_done),
    .o_status           (o_status),
    .o_out_buffer_id    (o_out_buffer_id),
    .o_out_frame_no     (o_out_frame_no),
    .o_out_handle       (o_out_handle),
    .o_repeat_found     (o_repeat_found),
    .o_filled_total     (o_filled_total),
    .o_handed_out_total (o_handed_out_total)
);

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for frame_buffer_pool_manager. A short directed sequence covers
// the corner cases of each command. Random phases then follow, each under a
// set pool size and command mix. A scoreboard class keeps its own copy of the
// free FIFO, the filled list and the delivery mark, predicts each result when
// its request is taken, and checks every strobed result against it in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fbpm_pkg::*;

    localparam int POOL_SIZE    = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 50;

    localparam t_op OP_SPARE_6 = 3'd6;
    localparam t_op OP_SPARE_7 = 3'd7;

    localparam logic [CFG_W-1:0] PHASE_SIZES [PHASES] =
        '{5'd0, 5'd1, 5'd31, 5'd2, 5'd16, 5'd5, 5'd17, 5'd12};
    localparam int PHASE_COMMIT_BIAS [PHASES] = '{0, 0, 60, 10, 40, 0, 80, 20};

    typedef struct packed {
        t_status status;
        t_id     buffer_id;
        t_frame  frame_no;
        t_handle handle;
        logic    repeat_found;
        t_total  filled_total;
        t_total  handed_out_total;
        t_total  free_total;
    } pool_result_t;

    class pool_scoreboard;
        t_id          free_ids[$];
        t_entry       filled[$];
        int           mark;
        int           pool_size;
        pool_result_t pending[$];
        int           errors;

        function new(int size);
            pool_size = size;
            errors    = 0;
            load_pool(RESET_BUFS);
        endfunction

        function void load_pool(int count);
            free_ids.delete();
            filled.delete();
            mark = 0;
            if (count > pool_size) begin
                count = pool_size;
            end
            for (int i = 0; i < count; i++) begin
                free_ids.push_back(t_id'(i));
            end
        endfunction

        function void push_free(t_id id);
            if (free_ids.size() < pool_size) begin
                free_ids.push_back(id);
            end
        endfunction

        function pool_result_t note_request(t_op op, t_id bid, t_frame fidx, t_handle hnd);
            pool_result_t res;
            t_entry       ent;
            res = '0;
            case (op)
                OP_ACQUIRE: begin
                    if (free_ids.size() == 0) begin
                        res.status = ST_NONE;
                    end else begin
                        res.buffer_id = free_ids.pop_front();
                    end
                end
                OP_COMMIT: begin
                    if (filled.size() >= pool_size) begin
                        res.status = ST_NONE;
                    end else begin
                        ent.id     = bid;
                        ent.frame  = fidx;
                        ent.handle = hnd;
                        filled.push_back(ent);
                    end
                end
                OP_GET: begin
                    if (mark < filled.size()) begin
                        res.buffer_id = filled[mark].id;
                        res.frame_no  = filled[mark].frame;
                        res.handle    = filled[mark].handle;
                        mark++;
                    end else begin
                        res.status = ST_NONE;
                    end
                end
                OP_RELEASE: begin
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < mark && i < filled.size(); i++) begin
                        if (filled[i].handle == hnd) begin
                            res.buffer_id = filled[i].id;
                            if (filled[i].frame != fidx) begin
                                res.status = ST_MISMATCH;
                            end else begin
                                res.status = ST_OK;
                                filled.delete(i);
                                mark--;
                                push_free(res.buffer_id);
                            end
                            break;
                        end
                    end
                end
                OP_RESET: begin
                    for (int i = mark; i < filled.size(); i++) begin
                        push_free(filled[i].id);
                    end
                    while (filled.size() > mark) begin
                        void'(filled.pop_back());
                    end
                end
                OP_REPEAT: begin
                    foreach (filled[i]) begin
                        if (filled[i].frame == fidx) begin
                            res.repeat_found = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            res.filled_total     = t_total'(filled.size());
            res.handed_out_total = t_total'(mark);
            res.free_total       = t_total'(free_ids.size());
            pending.push_back(res);
            return res;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(pool_result_t got);
            pool_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending: actual %0h", $time, got);
                return;
            end
            want = pending.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_buffer_id", 32'(want.buffer_id), 32'(got.buffer_id));
            compare_field("out_frame_no", want.frame_no, got.frame_no);
            compare_field("out_handle", want.handle, got.handle);
            compare_field("repeat_found", 32'(want.repeat_found), 32'(got.repeat_found));
            compare_field("filled_total", 32'(want.filled_total), 32'(got.filled_total));
            compare_field("handed_out_total", 32'(want.handed_out_total),
                          32'(got.handed_out_total));
            compare_field("free_total", 32'(want.free_total), 32'(got.free_total));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_op               i_op;
    t_id               i_buffer_id;
    t_frame            i_frame_no;
    t_handle           i_handle;
    logic              o_done;
    t_status           o_status;
    t_id               o_out_buffer_id;
    t_frame            o_out_frame_no;
    t_handle           o_out_handle;
    logic              o_repeat_found;
    t_total            o_filled_total;
    t_total            o_handed_out_total;
    t_total            o_free_total;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;

    pool_scoreboard    sb;
    t_id               held_ids[$];
    t_frame            next_frame;
    int                idle_cycles = 0;

    frame_buffer_pool_manager #(
        .POOL_SIZE(POOL_SIZE)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_buffer_id        (i_buffer_id),
        .i_frame_no         (i_frame_no),
        .i_handle           (i_handle),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_out_buffer_id    (o_out_buffer_id),
        .o_out_frame_no     (o_out_frame_no),
        .o_out_handle       (o_out_handle),
        .o_repeat_found     (o_repeat_found),
        .o_filled_total     (o_filled_total),
        .o_handed_out_total (o_handed_out_total),
        .o_free_total       (o_free_total),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            sb.check_result('{o_status, o_out_buffer_id, o_out_frame_no, o_out_handle,
                              o_repeat_found, o_filled_total, o_handed_out_total,
                              o_free_total});
        end
    end

    task automatic issue(t_op op, t_id bid, t_frame fidx, t_handle hnd, int gap);
        pool_result_t want;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_buffer_id <= bid;
        i_frame_no  <= fidx;
        i_handle    <= hnd;
        do @(posedge i_clk); while (busy !== 1'b0);
        want = sb.note_request(op, bid, fidx, hnd);
        if (op == OP_ACQUIRE && want.status == ST_OK) begin
            held_ids.push_back(want.buffer_id);
        end
    endtask

    task automatic write_pool_size(logic [CFG_W-1:0] count);
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sb.load_pool(count);
        held_ids.delete();
    endtask

    task automatic run_directed();
        issue(OP_GET, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_RELEASE, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_RESET, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_REPEAT, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_SPARE_6, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(OP_SPARE_7, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(OP_ACQUIRE, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_COMMIT, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(OP_COMMIT, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_COMMIT, 4'h7, 32'h1234_5678, 32'hA5A5_A5A5, 0);
        issue(OP_GET, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_GET, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_REPEAT, 4'h0, 32'hFFFF_FFFF, 32'h0, 0);
        issue(OP_RELEASE, 4'h0, 32'h1, 32'h0, 0);
        issue(OP_RELEASE, 4'h0, 32'h1234_5678, 32'hA5A5_A5A5, 0);
        issue(OP_RELEASE, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_RESET, 4'h0, 32'h0, 32'h0, 0);
        issue(OP_RELEASE, 4'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        issue(OP_GET, 4'h0, 32'h0, 32'h0, 0);
        write_pool_size(5'd0);
        issue(OP_ACQUIRE, 4'h0, 32'h0, 32'h0, 0);
    endtask

    task automatic pick_request(int commit_bias, output t_op op, output t_id bid,
                                output t_frame fidx, output t_handle hnd);
        int roll;
        int pos;
        op   = OP_ACQUIRE;
        bid  = t_id'($urandom);
        fidx = $urandom;
        hnd  = $urandom;
        if ($urandom_range(0, 99) < 20) begin
            op = t_op'($urandom_range(0, 7));
            if ($urandom_range(0, 1) == 1 && sb.filled.size() != 0) begin
                pos  = $urandom_range(0, sb.filled.size() - 1);
                hnd  = sb.filled[pos].handle;
                fidx = sb.filled[pos].frame;
            end
            return;
        end
        roll = $urandom_range(0, 94 + commit_bias);
        if (roll < 15) begin
            op = OP_ACQUIRE;
        end else if (roll < 35 + commit_bias) begin
            op = OP_COMMIT;
            if (held_ids.size() != 0) begin
                bid = held_ids.pop_front();
            end
            fidx       = next_frame;
            next_frame = next_frame + 1;
        end else if (roll < 55 + commit_bias) begin
            op = OP_GET;
        end else if (roll < 80 + commit_bias) begin
            op = OP_RELEASE;
            if (sb.mark > 0) begin
                pos  = $urandom_range(0, sb.mark - 1);
                hnd  = sb.filled[pos].handle;
                fidx = sb.filled[pos].frame;
                if ($urandom_range(0, 9) == 0) begin
                    fidx = fidx ^ (32'd1 << $urandom_range(0, 31));
                end
            end
        end else if (roll < 90 + commit_bias) begin
            op = OP_REPEAT;
            if ($urandom_range(0, 9) < 6 && sb.filled.size() != 0) begin
                fidx = sb.filled[$urandom_range(0, sb.filled.size() - 1)].frame;
            end
        end else begin
            op = OP_RESET;
        end
    endtask

    initial begin
        t_op     op;
        t_id     bid;
        t_frame  fidx;
        t_handle hnd;
        int      burst_left;
        int      gap;

        sb          = new(POOL_SIZE);
        next_frame  = $urandom;
        burst_left  = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_op        <= OP_ACQUIRE;
        i_buffer_id <= '0;
        i_frame_no  <= '0;
        i_handle    <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            write_pool_size((p == 5) ? 5'($urandom_range(3, 15)) : PHASE_SIZES[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                gap = 0;
                if (burst_left == 0) begin
                    gap        = $urandom_range(1, 16);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(1, 12);
                end
                burst_left--;
                pick_request(PHASE_COMMIT_BIAS[p], op, bid, fidx, hnd);
                issue(op, bid, fidx, hnd, gap);
            end
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

endmodule
